// ===== src/spot_pkg.sv =====
// Package for the separating-axis polygon overlap test.
// Holds sizes, saturation constants and the sequencer state type.
// No dependencies.
`default_nettype none
package spot_pkg;
   localparam int MAX_VERTICES = 16;
   localparam int STORE_DEPTH = 2 * MAX_VERTICES;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W = 16;
   localparam int AXIS_W = 17;
   localparam int PROD_W = 33;
   localparam int PROJ_W = 34;
   localparam int DEPTH_W = 35;
   localparam logic signed [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
   localparam logic signed [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_START = 11'b000_0000_0010,
      ST_RDA   = 11'b000_0000_0100,
      ST_RDB   = 11'b000_0000_1000,
      ST_AXIS  = 11'b000_0001_0000,
      ST_PRD   = 11'b000_0010_0000,
      ST_PMX   = 11'b000_0100_0000,
      ST_PMY   = 11'b000_1000_0000,
      ST_PACC  = 11'b001_0000_0000,
      ST_CMP   = 11'b010_0000_0000,
      ST_DONE  = 11'b100_0000_0000
   } state_type;
endpackage
`default_nettype wire

// ===== src/sat_polygon_overlap_test.sv =====
// Top level of the separating-axis overlap test for two convex polygons.
// Uses spot_pkg for sizes, constants and the sequencer state type.
//
// Channel   Ports                                         Direction
// input     start, busy, req_polygon_id, req_vertex_x/y,  in (busy out)
//           req_evaluate
// result    rsp_strobe, rsp_collided, rsp_overlap_depth,   out
//           rsp_vertex_overflow
// config    csr_write_enable, csr_write_data              in
//
// A word without evaluate is stored and busy stays low.
// A word with evaluate runs the test on one shared multiplier: each axis
// reads its edge and forms the axis, then projects every stored vertex of
// both polygons, then compares; the result shows in the cycle after the final compare.
// Reset clears counts, overflow flag and sequencer and sets both-axes mode; the store needs none.
// The receiver cannot stall; rsp_strobe marks a result for one cycle.
`default_nettype none
module sat_polygon_overlap_test (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_polygon_id,
   input  wire logic signed [15:0]                req_vertex_x,
   input  wire logic signed [15:0]                req_vertex_y,
   input  wire logic                              req_evaluate,
   output logic                                   rsp_strobe,
   output logic                                   rsp_collided,
   output logic signed [spot_pkg::DEPTH_W-1:0]    rsp_overlap_depth,
   output logic                                   rsp_vertex_overflow,
   input  wire logic                              csr_write_enable,
   input  wire logic                              csr_write_data
);
   logic [31:0] mem [spot_pkg::STORE_DEPTH];
   logic [31:0] rdata_ff;
   logic [spot_pkg::ADDR_W-1:0] rd_addr, wr_addr;

   spot_pkg::state_type state_ff, state_in;
   logic both_ff;
   logic [spot_pkg::CNT_W-1:0] cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic ovf_ff, ovf_in;
   logic p_ff, p_in, q_ff, q_in;
   logic [spot_pkg::IDX_W-1:0] a_ff, a_in, i_ff, i_in;
   logic [31:0] ea_ff, ea_in;
   logic signed [spot_pkg::AXIS_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic signed [spot_pkg::PROD_W-1:0] prod_ff, prod_in, px_ff, px_in;
   logic signed [spot_pkg::PROJ_W-1:0] lo0_ff, lo0_in, hi0_ff, hi0_in;
   logic signed [spot_pkg::PROJ_W-1:0] lo1_ff, lo1_in, hi1_ff, hi1_in;
   logic signed [spot_pkg::DEPTH_W-1:0] depth_ff, depth_in;
   logic coll_ff, coll_in;

   logic accept;
   logic [spot_pkg::CNT_W-1:0] n_p, n_q, a_next, i_next;
   logic [spot_pkg::IDX_W-1:0] b_idx;
   logic signed [spot_pkg::COORD_W-1:0] mul_a;
   logic signed [spot_pkg::AXIS_W-1:0] mul_b;
   logic signed [spot_pkg::PROD_W-1:0] mul_p;
   logic signed [spot_pkg::PROJ_W-1:0] proj;
   logic signed [spot_pkg::PROJ_W-1:0] hmin, lmax;
   logic signed [spot_pkg::DEPTH_W-1:0] ov;
   logic signed [spot_pkg::COORD_W:0] xa, ya, xb, yb;

   function automatic logic [spot_pkg::ADDR_W-1:0] vaddr(
      input logic poly, input logic [spot_pkg::IDX_W-1:0] idx);
      logic [spot_pkg::ADDR_W-1:0] base;
      base = poly ? spot_pkg::ADDR_W'(spot_pkg::MAX_VERTICES) : '0;
      return base + spot_pkg::ADDR_W'(idx);
   endfunction

   assign accept = start && !busy;
   assign busy = (state_ff != spot_pkg::ST_IDLE);
   assign rsp_strobe = (state_ff == spot_pkg::ST_DONE);
   assign rsp_collided = coll_ff;
   assign rsp_overlap_depth = depth_ff;
   assign rsp_vertex_overflow = ovf_ff;

   assign n_p = p_ff ? cnt1_ff : cnt0_ff;
   assign n_q = q_ff ? cnt1_ff : cnt0_ff;
   assign a_next = spot_pkg::CNT_W'(a_ff) + 1'b1;
   assign i_next = spot_pkg::CNT_W'(i_ff) + 1'b1;
   assign b_idx = (a_next == n_p) ? '0 : a_next[spot_pkg::IDX_W-1:0];
   assign wr_addr = vaddr(req_polygon_id,
      req_polygon_id ? cnt1_ff[spot_pkg::IDX_W-1:0] : cnt0_ff[spot_pkg::IDX_W-1:0]);

   always_comb begin
      unique case (state_ff)
         spot_pkg::ST_RDA: rd_addr = vaddr(p_ff, a_ff);
         spot_pkg::ST_RDB: rd_addr = vaddr(p_ff, b_idx);
         default:          rd_addr = vaddr(q_ff, i_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[rd_addr];
      if (accept && (req_polygon_id ? cnt1_ff : cnt0_ff) !=
          spot_pkg::CNT_W'(spot_pkg::MAX_VERTICES)) begin
         mem[wr_addr] <= {req_vertex_y, req_vertex_x};
      end
   end

   assign xa = {ea_ff[15], ea_ff[15:0]};
   assign ya = {ea_ff[31], ea_ff[31:16]};
   assign xb = {rdata_ff[15], rdata_ff[15:0]};
   assign yb = {rdata_ff[31], rdata_ff[31:16]};

   assign mul_a = (state_ff == spot_pkg::ST_PMX) ? $signed(rdata_ff[15:0])
                                                  : $signed(rdata_ff[31:16]);
   assign mul_b = (state_ff == spot_pkg::ST_PMX) ? ax_ff : ay_ff;
   assign mul_p = spot_pkg::PROD_W'(mul_a * mul_b);
   assign proj = spot_pkg::PROJ_W'(px_ff) + spot_pkg::PROJ_W'(prod_ff);
   assign hmin = (hi0_ff < hi1_ff) ? hi0_ff : hi1_ff;
   assign lmax = (lo0_ff > lo1_ff) ? lo0_ff : lo1_ff;
   assign ov = spot_pkg::DEPTH_W'(hmin) - spot_pkg::DEPTH_W'(lmax);

   always_comb begin
      state_in = state_ff;
      cnt0_in = cnt0_ff;
      cnt1_in = cnt1_ff;
      ovf_in = ovf_ff;
      p_in = p_ff;
      q_in = q_ff;
      a_in = a_ff;
      i_in = i_ff;
      ea_in = ea_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      prod_in = prod_ff;
      px_in = px_ff;
      lo0_in = lo0_ff;
      hi0_in = hi0_ff;
      lo1_in = lo1_ff;
      hi1_in = hi1_ff;
      depth_in = depth_ff;
      coll_in = coll_ff;
      unique case (state_ff)
         spot_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_polygon_id) begin
                  if (cnt1_ff == spot_pkg::CNT_W'(spot_pkg::MAX_VERTICES)) ovf_in = 1'b1;
                  else cnt1_in = cnt1_ff + 1'b1;
               end else begin
                  if (cnt0_ff == spot_pkg::CNT_W'(spot_pkg::MAX_VERTICES)) ovf_in = 1'b1;
                  else cnt0_in = cnt0_ff + 1'b1;
               end
               if (req_evaluate) state_in = spot_pkg::ST_START;
            end
         end
         spot_pkg::ST_START: begin
            depth_in = spot_pkg::DEPTH_MAX;
            coll_in = 1'b1;
            a_in = '0;
            if (cnt0_ff != '0) begin
               p_in = 1'b0;
               state_in = spot_pkg::ST_RDA;
            end else if (both_ff && cnt1_ff != '0) begin
               p_in = 1'b1;
               state_in = spot_pkg::ST_RDA;
            end else begin
               state_in = spot_pkg::ST_DONE;
            end
         end
         spot_pkg::ST_RDA: begin
            if (cnt0_ff == '0 || cnt1_ff == '0) begin
               coll_in = 1'b0;
               depth_in = spot_pkg::DEPTH_MIN;
               state_in = spot_pkg::ST_DONE;
            end else begin
               state_in = spot_pkg::ST_RDB;
            end
         end
         spot_pkg::ST_RDB: begin
            ea_in = rdata_ff;
            state_in = spot_pkg::ST_AXIS;
         end
         spot_pkg::ST_AXIS: begin
            ax_in = ya - yb;
            ay_in = xb - xa;
            q_in = 1'b0;
            i_in = '0;
            state_in = spot_pkg::ST_PRD;
         end
         spot_pkg::ST_PRD: state_in = spot_pkg::ST_PMX;
         spot_pkg::ST_PMX: begin
            prod_in = mul_p;
            state_in = spot_pkg::ST_PMY;
         end
         spot_pkg::ST_PMY: begin
            px_in = prod_ff;
            prod_in = mul_p;
            state_in = spot_pkg::ST_PACC;
         end
         spot_pkg::ST_PACC: begin
            if (!q_ff) begin
               if (i_ff == '0 || proj < lo0_ff) lo0_in = proj;
               if (i_ff == '0 || proj > hi0_ff) hi0_in = proj;
            end else begin
               if (i_ff == '0 || proj < lo1_ff) lo1_in = proj;
               if (i_ff == '0 || proj > hi1_ff) hi1_in = proj;
            end
            if (i_next != n_q) begin
               i_in = i_next[spot_pkg::IDX_W-1:0];
               state_in = spot_pkg::ST_PRD;
            end else if (!q_ff) begin
               q_in = 1'b1;
               i_in = '0;
               state_in = spot_pkg::ST_PRD;
            end else begin
               state_in = spot_pkg::ST_CMP;
            end
         end
         spot_pkg::ST_CMP: begin
            if (ov < depth_ff) depth_in = ov;
            if (!(hi1_ff >= lo0_ff && hi0_ff >= lo1_ff)) begin
               coll_in = 1'b0;
               state_in = spot_pkg::ST_DONE;
            end else if (a_next != n_p) begin
               a_in = a_next[spot_pkg::IDX_W-1:0];
               state_in = spot_pkg::ST_RDA;
            end else if (!p_ff && both_ff && cnt1_ff != '0) begin
               p_in = 1'b1;
               a_in = '0;
               state_in = spot_pkg::ST_RDA;
            end else begin
               state_in = spot_pkg::ST_DONE;
            end
         end
         spot_pkg::ST_DONE: begin
            cnt0_in = '0;
            cnt1_in = '0;
            ovf_in = 1'b0;
            state_in = spot_pkg::ST_IDLE;
         end
         default: state_in = spot_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= spot_pkg::ST_IDLE;
         cnt0_ff <= '0;
         cnt1_ff <= '0;
         ovf_ff <= 1'b0;
         both_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt0_ff <= cnt0_in;
         cnt1_ff <= cnt1_in;
         ovf_ff <= ovf_in;
         if (csr_write_enable) both_ff <= csr_write_data;
      end
      p_ff <= p_in;
      q_ff <= q_in;
      a_ff <= a_in;
      i_ff <= i_in;
      ea_ff <= ea_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      prod_ff <= prod_in;
      px_ff <= px_in;
      lo0_ff <= lo0_in;
      hi0_ff <= hi0_in;
      lo1_ff <= lo1_in;
      hi1_ff <= hi1_in;
      depth_ff <= depth_in;
      coll_ff <= coll_in;
   end
endmodule
`default_nettype wire

// ===== dv/sat_polygon_overlap_checker.sv =====
// Checker for the separating-axis polygon overlap test: watches the input and result
// channels, predicts each result and compares it field by field.
// Depends on spot_pkg for sizes and depth limits.
module sat_polygon_overlap_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           busy,
   input  wire logic                           req_polygon_id,
   input  wire logic signed [15:0]             req_vertex_x,
   input  wire logic signed [15:0]             req_vertex_y,
   input  wire logic                           req_evaluate,
   input  wire logic                           rsp_strobe,
   input  wire logic                           rsp_collided,
   input  wire logic signed [spot_pkg::DEPTH_W-1:0] rsp_overlap_depth,
   input  wire logic                           rsp_vertex_overflow,
   input  wire logic                           csr_write_enable,
   input  wire logic                           csr_write_data,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output int                                  verdict_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                                collided;
      logic signed [spot_pkg::DEPTH_W-1:0] depth;
      logic                                overflow;
   } verdict_type;

   logic signed [spot_pkg::COORD_W-1:0] px [2][spot_pkg::MAX_VERTICES];
   logic signed [spot_pkg::COORD_W-1:0] py [2][spot_pkg::MAX_VERTICES];
   int          vcount [2];
   bit          dropped;
   bit          both_axes;
   verdict_type verdict_q [$];

   assign pending_count = verdict_q.size();

   function automatic bit shadow(input int p, input longint ax, input longint ay,
                                 output longint lo, output longint hi);
      longint q;
      if (vcount[p] == 0) return 0;
      for (int i = 0; i < vcount[p]; i++) begin
         q = longint'(px[p][i]) * ax + longint'(py[p][i]) * ay;
         if (i == 0 || q < lo) lo = q;
         if (i == 0 || q > hi) hi = q;
      end
      return 1;
   endfunction

   function automatic verdict_type separate();
      verdict_type v;
      longint ax, ay, lo0, hi0, lo1, hi1, ov, d;
      int b;
      d = spot_pkg::DEPTH_MAX;
      v.collided = 1;
      v.overflow = dropped;
      for (int p = 0; p < (both_axes ? 2 : 1); p++) begin
         for (int a = 0; a < vcount[p]; a++) begin
            b = (a + 1 == vcount[p]) ? 0 : a + 1;
            ax = -(longint'(py[p][b]) - longint'(py[p][a]));
            ay = longint'(px[p][b]) - longint'(px[p][a]);
            if (!shadow(0, ax, ay, lo0, hi0) || !shadow(1, ax, ay, lo1, hi1)) begin
               v.collided = 0;
               v.depth = spot_pkg::DEPTH_MIN;
               return v;
            end
            ov = ((hi0 < hi1) ? hi0 : hi1) - ((lo0 > lo1) ? lo0 : lo1);
            if (ov < d) d = ov;
            if (!(hi1 >= lo0 && hi0 >= lo1)) begin
               v.collided = 0;
               v.depth = d[spot_pkg::DEPTH_W-1:0];
               return v;
            end
         end
      end
      v.depth = d[spot_pkg::DEPTH_W-1:0];
      return v;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t: %s got %0d expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      verdict_type w;
      if (reset) begin
         vcount = '{0, 0};
         dropped = 0;
         both_axes = 1;
         mismatch_count = 0;
         verdict_count = 0;
         verdict_q.delete();
      end else begin
         if (rsp_strobe) begin
            verdict_count++;
            if (verdict_q.size() == 0) report("unexpected word, collided", rsp_collided, -1);
            else begin
               w = verdict_q.pop_front();
               if (rsp_collided !== w.collided) report("collided", rsp_collided, w.collided);
               if (rsp_overlap_depth !== w.depth)
                  report("overlap_depth", rsp_overlap_depth, w.depth);
               if (rsp_vertex_overflow !== w.overflow)
                  report("vertex_overflow", rsp_vertex_overflow, w.overflow);
            end
         end
         if (csr_write_enable) both_axes = csr_write_data;
         if (start && !busy) begin
            if (vcount[req_polygon_id] < spot_pkg::MAX_VERTICES) begin
               px[req_polygon_id][vcount[req_polygon_id]] = req_vertex_x;
               py[req_polygon_id][vcount[req_polygon_id]] = req_vertex_y;
               vcount[req_polygon_id]++;
            end else dropped = 1;
            if (req_evaluate) begin
               verdict_q.push_back(separate());
               vcount = '{0, 0};
               dropped = 0;
            end
         end
      end
   end
endmodule

// ===== dv/sat_polygon_overlap_test_test.sv =====
// Testbench top for the separating-axis polygon overlap test: drives vertex words,
// mode writes and idle gaps, and gives the verdict. Depends on spot_pkg, the block
// and sat_polygon_overlap_checker.
module sat_polygon_overlap_test_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0, reset = 1, start = 0, busy;
   logic req_polygon_id = 0, req_evaluate = 0;
   logic signed [15:0] req_vertex_x = 0, req_vertex_y = 0;
   logic csr_write_enable = 0, csr_write_data = 0;
   logic rsp_strobe, rsp_collided, rsp_vertex_overflow;
   logic signed [spot_pkg::DEPTH_W-1:0] rsp_overlap_depth;
   int mismatch_count, pending_count, verdict_count;
   int words_sent = 0, gap_left = 0;
   bit calm = 0;

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   sat_polygon_overlap_test dut (.*);
   sat_polygon_overlap_checker checker_i (.*);

   task automatic send_vertex(input bit p, input logic [15:0] x, input logic [15:0] y,
                              input bit ev);
      if (!calm && gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 17);
      if (gap_left > 0) start <= 0;
      while (gap_left > 0) begin
         @(posedge clock);
         gap_left--;
      end
      start <= 1;
      req_polygon_id <= p;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_evaluate <= ev;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic write_mode(input bit m);
      start <= 0;
      @(posedge clock);
      while (busy || pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic logic [15:0] coord(input int spread);
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($signed($urandom_range(0, 2 * spread)) - spread);
      endcase
   endfunction

   // One random pair: sizes mostly small, sometimes empty or overfull polygons.
   task automatic send_pair();
      int n0, n1, cx, cy, r, spread, ord;
      real ang;
      n0 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
      n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20) : $urandom_range(1, 6);
      if (n0 + n1 == 0) n0 = 1;
      spread = ($urandom_range(0, 3) == 0) ? 32767 : 2000;
      for (int p = 0; p < 2; p++) begin
         cx = $signed($urandom_range(0, 4000)) - 2000;
         cy = $signed($urandom_range(0, 4000)) - 2000;
         r = $urandom_range(1, 1500);
         for (int i = 0; i < (p ? n1 : n0); i++) begin
            ord = (p == 1 && i == n1 - 1) ? 1 : 0;
            ang = 6.2831853 * i / ((p ? n1 : n0) > 16 ? 16 : (p ? n1 : n0));
            if ($urandom_range(0, 7) == 0)
               send_vertex(p, coord(spread), coord(spread), ord && n1 > 0);
            else
               send_vertex(p, 16'(cx + int'(r * $cos(ang))), 16'(cy + int'(r * $sin(ang))),
                           ord);
         end
      end
      if (n1 == 0) send_vertex(0, coord(2000), coord(2000), 1);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // Directed: extremes, a degenerate edge, an empty polygon and the no-axis case.
      send_vertex(1, 16'h8000, 16'h7FFF, 1);
      send_vertex(0, 16'h7FFF, 16'h8000, 0);
      send_vertex(0, 16'h8000, 16'h7FFF, 0);
      send_vertex(0, 16'h8000, 16'h8000, 0);
      send_vertex(1, 16'h7FFF, 16'h7FFF, 1);
      send_vertex(0, 16'h0100, 16'h0100, 1);
      send_vertex(0, 16'h0005, 16'h0005, 0);
      send_vertex(0, 16'h0005, 16'h0005, 0);
      send_vertex(1, 16'h0000, 16'h0000, 1);
      write_mode(0);
      send_vertex(1, 16'h1000, 16'h0000, 1);
      for (int i = 0; i < 18; i++)
         send_vertex(0, 16'(i * 64), 16'(i * i), i == 17);
      write_mode(1);
      while (words_sent < 1050) begin
         if ($urandom_range(0, 30) == 0) write_mode($urandom_range(0, 1));
         if (words_sent > 900) calm = 1;
         if ($urandom_range(0, 15) == 0)
            send_vertex($urandom_range(0, 1), 16'($urandom), 16'($urandom),
                        $urandom_range(0, 1));
         else send_pair();
      end
      start <= 0;
      @(posedge clock);
      while (busy || pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d vertex words and checked %0d results over both axis modes.",
               words_sent, verdict_count);
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
